[src/time_weighted_ewma_smoother_unit_assert.svh]
// Assertion macros, clocked on clk and held off while rst_n is low.
`ifndef TIME_WEIGHTED_EWMA_SMOOTHER_UNIT_ASSERT_SVH
`define TIME_WEIGHTED_EWMA_SMOOTHER_UNIT_ASSERT_SVH

// same-cycle implication
`define TWES_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TWES_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/twes_pkg.sv]
package twes_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int TIME_W        = 32;
    localparam int RAW_W         = 18;
    localparam int TAU_W         = 24;
    localparam int TC_BITS       = 16;
    localparam int DEN_W         = TIME_W + TC_BITS + 1;

    localparam logic [TAU_W-1:0] TAU_RESET   = 24'd104303;
    localparam logic             ACT_SAMPLE  = 1'b0;
    localparam logic             ACT_RESTART = 1'b1;

endpackage

[src/twes_mul.sv]
module twes_mul #(
    parameter int DW = twes_pkg::FRAC_BITS_DEF + 1
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [DW-1:0]                    mag,
    input  logic [twes_pkg::TAU_W-1:0]       tau,
    output logic                             done,
    output logic [DW+twes_pkg::TAU_W-1:0]    prod
);

    localparam int TW = twes_pkg::TAU_W;
    localparam int MW = DW + TW;
    localparam int CW = $clog2(DW + 1);

    logic          run_reg, run_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [MW-1:0] p_reg, p_next;
    logic [TW-1:0] tau_reg, tau_next;
    logic [TW:0]   sum;

    // shift-add, one multiplier bit per cycle, LSB first
    always_comb
    begin
        sum      = {1'b0, p_reg[MW-1:DW]} + (p_reg[0] ? {1'b0, tau_reg} : '0);
        run_next = run_reg;
        cnt_next = cnt_reg;
        p_next   = p_reg;
        tau_next = tau_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = CW'(DW);
            p_next   = MW'(mag);
            tau_next = tau;
        end
        else if (run_reg)
        begin
            if (cnt_reg == '0)
            begin
                run_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg - CW'(1);
                p_next   = {sum, p_reg[DW-1:1]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg   <= p_next;
        tau_reg <= tau_next;
    end

    assign done = run_reg && (cnt_reg == '0);
    assign prod = p_reg;

endmodule

[src/twes_div.sv]
module twes_div #(
    parameter int NW   = 50,
    parameter int DENW = twes_pkg::DEN_W,
    parameter int QW   = twes_pkg::FRAC_BITS_DEF + 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [NW-1:0]   num,
    input  logic [DENW-1:0] den,
    output logic            done,
    output logic [QW-1:0]   quo
);

    localparam int CW = $clog2(QW + 1);

    logic            run_reg, run_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [DENW-1:0] rem_reg, rem_next;
    logic [DENW-1:0] den_reg, den_next;
    logic [QW-1:0]   nlo_reg, nlo_next;
    logic [QW-1:0]   q_reg, q_next;
    logic [DENW:0]   trial;
    logic            ge;

    // restoring division, one quotient bit per cycle; quotient known to fit QW bits
    always_comb
    begin
        trial    = {rem_reg, nlo_reg[QW-1]};
        ge       = trial >= {1'b0, den_reg};
        run_next = run_reg;
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        nlo_next = nlo_reg;
        q_next   = q_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = CW'(QW);
            rem_next = DENW'(num >> QW);
            den_next = den;
            nlo_next = num[QW-1:0];
        end
        else if (run_reg)
        begin
            if (cnt_reg == '0)
            begin
                run_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg - CW'(1);
                rem_next = ge ? DENW'(trial - {1'b0, den_reg}) : DENW'(trial);
                nlo_next = {nlo_reg[QW-2:0], 1'b0};
                q_next   = {q_reg[QW-2:0], ge};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        nlo_reg <= nlo_next;
        q_reg   <= q_next;
    end

    assign done = run_reg && (cnt_reg == '0);
    assign quo  = q_reg;

endmodule

[src/time_weighted_ewma_smoother_unit.sv]
// Channel   Direction  Handshake           Word
// input     in         in_valid/in_stall   action, sample_time, raw_level
// output    out        out_valid/out_stall smoothed_level
// config    in         cfg_wr_en           cfg_wr_data (time constant, Q8.16 s)
//
// Restart and repeated-timestamp words give no result and leave the block idle. Pass-through
// words go straight to DONE, which loads the output register. Filtered words pass through MUL,
// PREP, DIV and DONE, worked by the bit-serial multiplier and divider; the next word can be
// taken in the cycle after the result is loaded.
// Reset: time constant 104303, level 0, no timestamp held.
// in_stall is high while a word is in work, including while a result waits on a full,
// stalled output register; a loaded result may wait while the next word is taken.
`include "time_weighted_ewma_smoother_unit_assert.svh"

module time_weighted_ewma_smoother_unit #(
    parameter int FRAC_BITS = twes_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              action,
    input  logic [twes_pkg::TIME_W-1:0]       sample_time,
    input  logic signed [twes_pkg::RAW_W-1:0] raw_level,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [FRAC_BITS:0]                smoothed_level,
    input  logic                              cfg_wr_en,
    input  logic [twes_pkg::TAU_W-1:0]        cfg_wr_data
);

    localparam int LW   = FRAC_BITS + 1;
    localparam int TW   = twes_pkg::TAU_W;
    localparam int TMW  = twes_pkg::TIME_W;
    localparam int MW   = LW + TW;
    localparam int DENW = twes_pkg::DEN_W;
    localparam int NW   = ((MW > DENW) ? MW : DENW) + 1;
    localparam int CLW  = (twes_pkg::RAW_W > LW + 1) ? twes_pkg::RAW_W : LW + 1;
    localparam logic [LW-1:0] ONE_L = LW'(1) << FRAC_BITS;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_PREP = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t         state_reg, state_next;
    logic [TMW-1:0] last_reg, last_next;
    logic [LW-1:0]  level_reg, level_next;
    logic [TW-1:0]  tau_reg, tau_next;
    logic           out_valid_reg, out_valid_next;
    logic [LW-1:0]  out_data_reg, out_data_next;
    logic [TMW-1:0] dt_reg, dt_next;
    logic [LW-1:0]  raw_reg, raw_next;
    logic           neg_reg, neg_next;
    logic [LW-1:0]  mag_reg, mag_next;
    logic [DENW-1:0] den_reg, den_next;
    logic [LW-1:0]  res_reg, res_next;

    logic           in_accept;
    logic [CLW-1:0] raw_ext;
    logic [LW-1:0]  raw_clamped;
    logic           mul_start, mul_done, div_start, div_done;
    logic [MW-1:0]  prod;
    logic [NW-1:0]  num;
    logic [LW-1:0]  quo;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign raw_ext   = CLW'(raw_level);

    always_comb
    begin
        if (raw_ext[CLW-1])
        begin
            raw_clamped = '0;
        end
        else if (raw_ext[CLW-2:0] > (CLW-1)'(ONE_L))
        begin
            raw_clamped = ONE_L;
        end
        else
        begin
            raw_clamped = LW'(raw_ext);
        end
    end

    assign num = NW'(prod) + NW'(den_reg >> 1);

    always_comb
    begin
        state_next     = state_reg;
        last_next      = last_reg;
        level_next     = level_reg;
        tau_next       = tau_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        dt_next        = dt_reg;
        raw_next       = raw_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        den_next       = den_reg;
        res_next       = res_reg;
        mul_start      = 1'b0;
        div_start      = 1'b0;

        if (cfg_wr_en)
        begin
            tau_next = cfg_wr_data;
        end
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (action == twes_pkg::ACT_RESTART)
                    begin
                        last_next = '0;
                    end
                    else if (sample_time != last_reg)
                    begin
                        last_next = sample_time;
                        if (last_reg == '0 || sample_time < last_reg || tau_reg == '0)
                        begin
                            res_next   = raw_clamped;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            dt_next    = sample_time - last_reg;
                            raw_next   = raw_clamped;
                            neg_next   = raw_clamped < level_reg;
                            mag_next   = (raw_clamped < level_reg) ? level_reg - raw_clamped
                                                                   : raw_clamped - level_reg;
                            mul_start  = 1'b1;
                            state_next = ST_MUL;
                        end
                    end
                end
            end
            ST_MUL:
            begin
                den_next = (DENW'(dt_reg) << twes_pkg::TC_BITS) + DENW'(tau_reg);
                if (mul_done)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    res_next   = neg_reg ? raw_reg + quo : raw_reg - quo;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    level_next     = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            last_reg      <= '0;
            level_reg     <= '0;
            tau_reg       <= twes_pkg::TAU_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_reg      <= last_next;
            level_reg     <= level_next;
            tau_reg       <= tau_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        dt_reg       <= dt_next;
        raw_reg      <= raw_next;
        neg_reg      <= neg_next;
        mag_reg      <= mag_next;
        den_reg      <= den_next;
        res_reg      <= res_next;
    end

    // the multiplier loads on the accepting edge, so it takes the step being registered
    twes_mul #(
        .DW (LW)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .mag   (mag_next),
        .tau   (tau_reg),
        .done  (mul_done),
        .prod  (prod)
    );

    twes_div #(
        .NW   (NW),
        .DENW (DENW),
        .QW   (LW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num),
        .den   (den_reg),
        .done  (div_done),
        .quo   (quo)
    );

    assign out_valid      = out_valid_reg;
    assign smoothed_level = out_data_reg;

    `TWES_ASSERT_NOW(a_mul_done_in_mul, mul_done, state_reg == ST_MUL, "multiplier done outside MUL")
    `TWES_ASSERT_NOW(a_div_done_in_div, div_done, state_reg == ST_DIV, "divider done outside DIV")
    `TWES_ASSERT_NOW(a_quo_bounded, div_done, quo <= mag_reg, "quotient above level step")
    `TWES_ASSERT_NOW(a_out_in_range, out_valid_reg, out_data_reg <= ONE_L, "smoothed level above one")
    `TWES_ASSERT_NXT(a_done_drains, (state_reg == ST_DONE) && !out_valid_reg, (state_reg == ST_IDLE) && out_valid_reg, "result not loaded")

endmodule

[test/time_weighted_ewma_smoother_unit_checker.sv]
`timescale 1ns / 100ps

module time_weighted_ewma_smoother_unit_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic                              action,
    input  logic [twes_pkg::TIME_W-1:0]       sample_time,
    input  logic signed [twes_pkg::RAW_W-1:0] raw_level,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic [twes_pkg::FRAC_BITS_DEF:0]  smoothed_level,
    input  logic                              cfg_wr_en,
    input  logic [twes_pkg::TAU_W-1:0]        cfg_wr_data,
    output int                                errors,
    output int                                pending
);

    typedef longint unsigned u64_t;

    localparam int     LVL_W      = twes_pkg::FRAC_BITS_DEF + 1;
    localparam longint FULL_SCALE = longint'(1) << twes_pkg::FRAC_BITS_DEF;

    logic [twes_pkg::TAU_W-1:0]  tau;
    logic [twes_pkg::TIME_W-1:0] last_seen;
    logic [LVL_W-1:0]            level_now;
    logic [LVL_W-1:0]            level_q[$];

    function automatic longint clamp_raw_level(input logic signed [twes_pkg::RAW_W-1:0] r);
        longint v;
        v = r;
        if (v < 0)
            return 0;
        if (v > FULL_SCALE)
            return FULL_SCALE;
        return v;
    endfunction

    // raw - (raw - old) * tau / (dt.16 + tau), rounded half away from zero
    function automatic logic [LVL_W-1:0] blend_level(input longint target,
                                                     input longint prior,
                                                     input logic [twes_pkg::TIME_W-1:0] dt,
                                                     input logic [twes_pkg::TAU_W-1:0] tc);
        u64_t   den;
        u64_t   mag;
        u64_t   q;
        longint diff;
        den  = (u64_t'(dt) << twes_pkg::TC_BITS) + u64_t'(tc);
        diff = target - prior;
        mag  = u64_t'(diff < 0 ? -diff : diff) * u64_t'(tc);
        q    = (mag + den / 2) / den;
        if (diff < 0)
            return LVL_W'(target + longint'(q));
        return LVL_W'(target - longint'(q));
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        logic [LVL_W-1:0] want;
        longint           raw;
        if (!rst_n)
        begin
            tau       = twes_pkg::TAU_RESET;
            last_seen = '0;
            level_now = '0;
            level_q.delete();
            errors    = 0;
            pending   = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (level_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: smoothed_level expected none, got %0d",
                             $time, smoothed_level);
                end
                else
                begin
                    want = level_q.pop_front();
                    if (smoothed_level !== want)
                    begin
                        errors++;
                        $display("%0t: smoothed_level expected %0d, got %0d",
                                 $time, want, smoothed_level);
                    end
                end
            end
            if (cfg_wr_en)
                tau = cfg_wr_data;
            if (in_valid && !in_stall)
            begin
                if (action == twes_pkg::ACT_RESTART)
                    last_seen = '0;
                else if (sample_time != last_seen)
                begin
                    raw = clamp_raw_level(raw_level);
                    if (last_seen == 0 || sample_time < last_seen || tau == 0)
                        level_now = LVL_W'(raw);
                    else
                        level_now = blend_level(raw, longint'(level_now),
                                                sample_time - last_seen, tau);
                    last_seen = sample_time;
                    level_q.push_back(level_now);
                end
            end
            pending = level_q.size();
        end
    end

endmodule

[test/time_weighted_ewma_smoother_unit_tb.sv]
`timescale 1ns / 100ps

module time_weighted_ewma_smoother_unit_tb;

    localparam int LVL_W         = twes_pkg::FRAC_BITS_DEF + 1;
    localparam int TIME_W        = twes_pkg::TIME_W;
    localparam int RAW_W         = twes_pkg::RAW_W;
    localparam int TAU_W         = twes_pkg::TAU_W;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 50;
    localparam int PHASE_WORDS   = 100;
    localparam int PHASES        = 6;

    logic                    clk         = 1'b0;
    logic                    rst_n       = 1'b0;
    logic                    in_valid    = 1'b0;
    logic                    in_stall;
    logic                    action      = twes_pkg::ACT_SAMPLE;
    logic [TIME_W-1:0]       sample_time = '0;
    logic signed [RAW_W-1:0] raw_level   = '0;
    logic                    out_valid;
    logic                    out_stall   = 1'b0;
    logic [LVL_W-1:0]        smoothed_level;
    logic                    cfg_wr_en   = 1'b0;
    logic [TAU_W-1:0]        cfg_wr_data = '0;

    int                chk_errors;
    int                chk_pending;
    bit                quiet       = 1'b0;
    int                idle_cycles = 0;
    logic [TIME_W-1:0] time_cursor = '0;
    logic [TAU_W-1:0]  tau_list[PHASES];

    time_weighted_ewma_smoother_unit #(
        .FRAC_BITS(twes_pkg::FRAC_BITS_DEF)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .action(action),
        .sample_time(sample_time),
        .raw_level(raw_level),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .smoothed_level(smoothed_level),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    time_weighted_ewma_smoother_unit_checker u_check (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .action(action),
        .sample_time(sample_time),
        .raw_level(raw_level),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .smoothed_level(smoothed_level),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .errors(chk_errors),
        .pending(chk_pending)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
        out_stall <= !quiet && ($urandom_range(99) < 10);

    always @(posedge clk)
    begin
        if (rst_n && !((in_valid && !in_stall) || (out_valid && !out_stall)))
            idle_cycles <= idle_cycles + 1;
        else
            idle_cycles <= 0;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_word(input logic act, input logic [TIME_W-1:0] t,
                             input logic signed [RAW_W-1:0] r);
        if (!quiet && $urandom_range(99) < 12)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 45)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        action      <= act;
        sample_time <= t;
        raw_level   <= r;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // ignored words give no result, so allow the block to finish them too
    task automatic wait_drained;
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (chk_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_tau(input logic [TAU_W-1:0] v);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic random_word;
        int                      pick;
        int                      span;
        logic signed [RAW_W-1:0] r;
        pick = $urandom_range(99);
        span = $urandom_range(99);
        if ($urandom_range(3) == 0)
            r = RAW_W'($urandom);
        else
            r = RAW_W'($urandom_range(65536));
        if (pick < 6)
            send_word(twes_pkg::ACT_RESTART, $urandom, r);
        else if (pick < 11)
            send_word(twes_pkg::ACT_SAMPLE, time_cursor, r);
        else
        begin
            if (pick < 16)
                time_cursor = time_cursor - $urandom_range(1, 50);
            else if (span < 70)
                time_cursor = time_cursor + $urandom_range(1, 10);
            else if (span < 92)
                time_cursor = time_cursor + $urandom_range(11, 100000);
            else
                time_cursor = time_cursor + $urandom;
            send_word(twes_pkg::ACT_SAMPLE, time_cursor, r);
        end
    endtask

    initial
    begin
        tau_list = '{twes_pkg::TAU_RESET, 24'd0, 24'hFFFFFF, 24'd1, 24'd65536, 24'd0};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(twes_pkg::ACT_SAMPLE, 32'd0, 18'd1000);
        send_word(twes_pkg::ACT_SAMPLE, 32'd10, 18'h20000);
        send_word(twes_pkg::ACT_SAMPLE, 32'd10, 18'd5000);
        send_word(twes_pkg::ACT_SAMPLE, 32'd11, 18'h1FFFF);
        send_word(twes_pkg::ACT_SAMPLE, 32'd20, 18'd65536);
        send_word(twes_pkg::ACT_SAMPLE, 32'd21, 18'd65537);
        send_word(twes_pkg::ACT_SAMPLE, 32'd5, 18'd30000);
        send_word(twes_pkg::ACT_RESTART, $urandom, 18'h15555);
        send_word(twes_pkg::ACT_SAMPLE, 32'd6, 18'd40000);
        send_word(twes_pkg::ACT_SAMPLE, 32'hFFFFFFFF, 18'd0);
        send_word(twes_pkg::ACT_SAMPLE, 32'd0, 18'd20000);
        send_word(twes_pkg::ACT_SAMPLE, 32'd1, 18'd100);
        send_word(twes_pkg::ACT_SAMPLE, 32'd2, 18'h3FFFF);
        send_word(twes_pkg::ACT_RESTART, 32'hAAAAAAAA, 18'h2AAAA);
        send_word(twes_pkg::ACT_SAMPLE, 32'd0, 18'd777);
        send_word(twes_pkg::ACT_SAMPLE, 32'd3, 18'd65535);
        send_word(twes_pkg::ACT_SAMPLE, 32'd4, 18'd32768);
        write_tau(24'd0);
        send_word(twes_pkg::ACT_SAMPLE, 32'd100, 18'd1234);
        send_word(twes_pkg::ACT_SAMPLE, 32'd101, 18'd60000);
        write_tau(24'hFFFFFF);
        send_word(twes_pkg::ACT_SAMPLE, 32'd102, 18'd0);
        send_word(twes_pkg::ACT_SAMPLE, 32'd50102, 18'd65536);
        send_word(twes_pkg::ACT_SAMPLE, 32'd50103, 18'd12345);
        time_cursor = 32'd50103;

        for (int p = 0; p < PHASES; p++)
        begin
            write_tau(p == PHASES - 1 ? TAU_W'($urandom) : tau_list[p]);
            quiet = (p == 1);
            for (int i = 0; i < PHASE_WORDS; i++)
            begin
                if (p == 3 && i == PHASE_WORDS / 2)
                    wait_drained();
                random_word();
            end
        end

        wait_drained();
        if (chk_errors == 0 && chk_pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[files.f]
+incdir+src
src/twes_pkg.sv
src/twes_mul.sv
src/twes_div.sv
src/time_weighted_ewma_smoother_unit.sv
test/time_weighted_ewma_smoother_unit_checker.sv
test/time_weighted_ewma_smoother_unit_tb.sv
